// File: hdl/hng_pkg.sv
// hng_pkg: widths, reset values, register indexes and the microcode table
// of the hysteresis noise gate sequencer
// depends on nothing; imported by hysteresis_noise_gate and the testbench
`default_nettype none

package hng_pkg;

  // sample and coefficient formats
  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 24;
  localparam int COEF_W         = 24;
  localparam int THR_W          = 16;
  localparam int CFG_W          = 24;
  localparam int CFG_IDX_W      = 3;

  // envelope: magnitude with fraction bits; gain: 0 .. 2^F inclusive
  localparam int ENV_W  = SAMPLE_BITS + COEF_FRAC_BITS;
  localparam int GAIN_W = COEF_FRAC_BITS + 1;

  // shared multiplier operands
  localparam int MA_W   = ENV_W;
  localparam int MB_W   = (GAIN_W > COEF_W) ? GAIN_W : COEF_W;
  localparam int PROD_W = MA_W + MB_W;

  // open level is close level * OPEN_NUM / OPEN_DEN (+3 dB)
  localparam int OPEN_NUM    = 1414;
  localparam int OPEN_DEN    = 1000;
  localparam int OPEN_NUM_W  = 11;
  localparam int OPEN_DEN_W  = 10;
  localparam int THR_OPEN_W  = THR_W + OPEN_NUM_W;
  localparam int CMP_OPEN_W  = ((THR_OPEN_W + COEF_FRAC_BITS) > (ENV_W + OPEN_DEN_W)) ?
                               (THR_OPEN_W + COEF_FRAC_BITS) : (ENV_W + OPEN_DEN_W);
  localparam int CMP_CLOSE_W = ((THR_W + COEF_FRAC_BITS) > ENV_W) ?
                               (THR_W + COEF_FRAC_BITS) : ENV_W;

  // register reset values
  localparam int THR_RESET     = 328;
  localparam int ATTACK_RESET  = 69760;
  localparam int RELEASE_RESET = 3495;
  localparam int SMOOTH_RESET  = 16777;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << COEF_FRAC_BITS;
  localparam logic [ENV_W-1:0]  ENV_MAX  = ENV_W'(1) << (ENV_W - 1);
  localparam logic [ENV_W-1:0]  RND_HALF = ENV_W'(1) << (COEF_FRAC_BITS - 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_THRESHOLD  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEF      = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEF     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_SMOOTH_COEF = CFG_IDX_W'(3);

  // microcode
  localparam int STEP_W = 3;

  typedef enum logic [2:0] {
    OP_ENV_MUL,
    OP_ENV_UPD,
    OP_GATE,
    OP_GAIN_MUL,
    OP_GAIN_UPD,
    OP_OUT_MUL,
    OP_OUT_WR
  } op_t;

  typedef enum logic {
    COND_NONE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
    logic              last;
  } ctrl_t;

  localparam logic [STEP_W-1:0] STEP_ENV_MUL  = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_ENV_UPD  = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_GATE     = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_GAIN_MUL = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_GAIN_UPD = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_OUT_MUL  = STEP_W'(5);
  localparam logic [STEP_W-1:0] STEP_OUT_WR   = STEP_W'(6);

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{op: OP_OUT_WR, cond: COND_OUT_BUSY, target: STEP_OUT_WR, last: 1'b1};
    unique case (step)
      STEP_ENV_MUL:  w = '{op: OP_ENV_MUL,  cond: COND_NONE, target: STEP_ENV_MUL, last: 1'b0};
      STEP_ENV_UPD:  w = '{op: OP_ENV_UPD,  cond: COND_NONE, target: STEP_ENV_MUL, last: 1'b0};
      STEP_GATE:     w = '{op: OP_GATE,     cond: COND_NONE, target: STEP_ENV_MUL, last: 1'b0};
      STEP_GAIN_MUL: w = '{op: OP_GAIN_MUL, cond: COND_NONE, target: STEP_ENV_MUL, last: 1'b0};
      STEP_GAIN_UPD: w = '{op: OP_GAIN_UPD, cond: COND_NONE, target: STEP_ENV_MUL, last: 1'b0};
      STEP_OUT_MUL:  w = '{op: OP_OUT_MUL,  cond: COND_NONE, target: STEP_ENV_MUL, last: 1'b0};
      STEP_OUT_WR:   w = '{op: OP_OUT_WR, cond: COND_OUT_BUSY, target: STEP_OUT_WR, last: 1'b1};
      default:       w = '{op: OP_OUT_WR, cond: COND_OUT_BUSY, target: STEP_OUT_WR, last: 1'b1};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hdl/hysteresis_noise_gate.sv
// hysteresis_noise_gate: envelope follower, hysteresis gate, smoothed gain
// microcoded sequencer over one shared multiplier; depends on hng_pkg
//
// channel  direction  handshake              payload
// in       sink       in_valid / in_stall    sample_in, block_start
// out      source     out_valid / out_stall  sample_out, gate_is_open
// cfg      sink       cfg_we                 cfg_index, cfg_data
//
// a word runs through one microcode step after another, an order set by the single shared
// multiplier that is used three times (envelope, gain, output product)
// the next word is taken the cycle after the result is registered
// if the output register is still full and stalled, the last step repeats
// rst clears control state, registers go to their reset values, gain to 1.0
`default_nettype none

module hysteresis_noise_gate (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire logic signed [hng_pkg::SAMPLE_BITS-1:0] sample_in,
  input  wire logic                               block_start,
  output      logic                               out_valid,
  input  wire logic                               out_stall,
  output      logic signed [hng_pkg::SAMPLE_BITS-1:0] sample_out,
  output      logic                               gate_is_open,
  input  wire logic                               cfg_we,
  input  wire logic [hng_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [hng_pkg::CFG_W-1:0]          cfg_data
);
  import hng_pkg::*;

  // configuration registers; open level kept premultiplied by OPEN_NUM
  logic [THR_W-1:0]      close_threshold;
  logic [THR_OPEN_W-1:0] open_threshold;
  logic [COEF_W-1:0]     attack_coef;
  logic [COEF_W-1:0]     release_coef;
  logic [COEF_W-1:0]     gain_smooth_coef;

  // filter state
  logic [ENV_W-1:0]  envelope_level;
  logic              gate_state;
  logic [GAIN_W-1:0] gain_level;

  // sequencer
  logic              busy, busy_next;
  logic [STEP_W-1:0] step, step_next;
  ctrl_t             ctrl;
  logic              out_block;
  logic              jump;
  logic              do_op;
  logic              in_accept;

  // datapath
  logic [SAMPLE_BITS-1:0] mag;
  logic                   neg;
  logic                   dir;
  logic [PROD_W-1:0]      prod;

  logic [ENV_W-1:0]       rect;
  logic                   env_rise;
  logic [ENV_W-1:0]       env_diff;
  logic [COEF_W-1:0]      env_coef;
  logic [GAIN_W-1:0]      gain_target;
  logic                   gain_rise;
  logic [GAIN_W-1:0]      gain_diff;
  logic [MA_W-1:0]        mul_a;
  logic [MB_W-1:0]        mul_b;
  logic                   mul_en;
  logic [ENV_W-1:0]       env_step;
  logic [GAIN_W-1:0]      gain_step;
  logic [CMP_OPEN_W-1:0]  env_scaled;
  logic [CMP_OPEN_W-1:0]  open_level;
  logic [CMP_CLOSE_W-1:0] close_level;
  logic                   gate_next;
  logic [ENV_W-1:0]       rnd_sum;
  logic [SAMPLE_BITS-1:0] rnd_mag;
  logic [SAMPLE_BITS-1:0] res;

  // ---------------------------------------------------------------- control
  assign ctrl      = ucode(step);
  assign out_block = out_valid && out_stall;
  // conditional jump: hold on the write step while the output is occupied
  assign jump      = (ctrl.cond == COND_OUT_BUSY) && out_block;
  assign do_op     = busy && !jump;
  assign in_stall  = busy || rst;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    busy_next = busy;
    step_next = step;
    if (!busy) begin
      if (in_accept) begin
        busy_next = 1'b1;
        step_next = STEP_ENV_MUL;
      end
    end else if (jump) begin
      step_next = ctrl.target;
    end else if (ctrl.last) begin
      busy_next = 1'b0;
      step_next = STEP_ENV_MUL;
    end else begin
      step_next = step + STEP_W'(1);
    end
  end

  // --------------------------------------------------------------- datapath
  // rectified sample in envelope units, and the direction of each filter
  assign rect        = {mag, {COEF_FRAC_BITS{1'b0}}};
  assign env_rise    = rect > envelope_level;
  assign env_diff    = env_rise ? (rect - envelope_level) : (envelope_level - rect);
  assign env_coef    = env_rise ? attack_coef : release_coef;
  assign gain_target = gate_state ? GAIN_ONE : '0;
  assign gain_rise   = gain_target > gain_level;
  assign gain_diff   = gain_rise ? (gain_target - gain_level)
                                 : (gain_level - gain_target);

  // operand select for the shared multiplier
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b0;
    unique case (ctrl.op)
      OP_ENV_MUL: begin
        mul_a  = env_diff;
        mul_b  = MB_W'(env_coef);
        mul_en = 1'b1;
      end
      OP_GAIN_MUL: begin
        mul_a  = MA_W'(gain_diff);
        mul_b  = MB_W'(gain_smooth_coef);
        mul_en = 1'b1;
      end
      OP_OUT_MUL: begin
        mul_a  = MA_W'(mag);
        mul_b  = MB_W'(gain_level);
        mul_en = 1'b1;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // filter steps, truncated toward zero so neither filter overshoots
  assign env_step  = prod[COEF_FRAC_BITS+ENV_W-1:COEF_FRAC_BITS];
  assign gain_step = prod[COEF_FRAC_BITS+GAIN_W-1:COEF_FRAC_BITS];

  // exact hysteresis tests: env*1000 >= thr*1414 opens, env < thr closes
  assign env_scaled  = CMP_OPEN_W'(envelope_level) * CMP_OPEN_W'(OPEN_DEN);
  assign open_level  = CMP_OPEN_W'({open_threshold, {COEF_FRAC_BITS{1'b0}}});
  assign close_level = CMP_CLOSE_W'({close_threshold, {COEF_FRAC_BITS{1'b0}}});
  assign gate_next   = gate_state ? !(CMP_CLOSE_W'(envelope_level) < close_level)
                                  : (env_scaled >= open_level);

  // output: round magnitude half away from zero, then apply the sign
  assign rnd_sum = prod[ENV_W-1:0] + RND_HALF;
  assign rnd_mag = rnd_sum[ENV_W-1:COEF_FRAC_BITS];
  assign res     = neg ? (~rnd_mag + SAMPLE_BITS'(1)) : rnd_mag;

  // ---------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (rst) begin
      busy             <= 1'b0;
      step             <= STEP_ENV_MUL;
      out_valid        <= 1'b0;
      envelope_level   <= '0;
      gate_state       <= 1'b0;
      gain_level       <= GAIN_ONE;
      close_threshold  <= THR_W'(THR_RESET);
      open_threshold   <= THR_OPEN_W'(THR_RESET * OPEN_NUM);
      attack_coef      <= COEF_W'(ATTACK_RESET);
      release_coef     <= COEF_W'(RELEASE_RESET);
      gain_smooth_coef <= COEF_W'(SMOOTH_RESET);
    end else begin
      busy <= busy_next;
      step <= step_next;

      // result register: a load wins over a drain in the same cycle
      if (do_op && ctrl.op == OP_OUT_WR) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // block start clears envelope and gate, gain carries over
      if (in_accept && block_start) begin
        envelope_level <= '0;
        gate_state     <= 1'b0;
      end

      if (do_op) begin
        unique case (ctrl.op)
          OP_ENV_UPD: begin
            envelope_level <= dir ? (envelope_level + env_step)
                                  : (envelope_level - env_step);
          end
          OP_GATE: begin
            gate_state <= gate_next;
          end
          OP_GAIN_UPD: begin
            gain_level <= dir ? (gain_level + gain_step)
                              : (gain_level - gain_step);
          end
          default: begin
          end
        endcase
      end

      if (cfg_we) begin
        unique case (cfg_index)
          REG_CLOSE_THRESHOLD: begin
            close_threshold <= cfg_data[THR_W-1:0];
            open_threshold  <= THR_OPEN_W'(cfg_data[THR_W-1:0]) * THR_OPEN_W'(OPEN_NUM);
          end
          REG_ATTACK_COEF:      attack_coef      <= cfg_data[COEF_W-1:0];
          REG_RELEASE_COEF:     release_coef     <= cfg_data[COEF_W-1:0];
          REG_GAIN_SMOOTH_COEF: gain_smooth_coef <= cfg_data[COEF_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------- payload regs
  always_ff @(posedge clk) begin
    if (in_accept) begin
      // two's complement magnitude; the most negative value maps to 2^(n-1)
      neg <= sample_in[SAMPLE_BITS-1];
      mag <= sample_in[SAMPLE_BITS-1] ? (~sample_in + SAMPLE_BITS'(1)) : sample_in;
    end
    if (do_op && mul_en) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
      dir  <= (ctrl.op == OP_ENV_MUL) ? env_rise : gain_rise;
    end
    if (do_op && ctrl.op == OP_OUT_WR) begin
      sample_out   <= res;
      gate_is_open <= gate_state;
    end
  end

`ifndef SYNTHESIS
  a_gain_bounded: assert property (@(posedge clk) disable iff (rst)
    gain_level <= GAIN_ONE)
    else $error("smoothed gain above unity");

  a_env_bounded: assert property (@(posedge clk) disable iff (rst)
    envelope_level <= ENV_MAX)
    else $error("envelope above full-scale rectified input");

  a_load_at_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(busy && ctrl.last))
    else $error("result word appeared outside the write step");

  a_start_seq: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (busy && step == STEP_ENV_MUL))
    else $error("accepted word did not start the microprogram");
`endif

endmodule

`default_nettype wire

// File: tb/testbench.sv
// testbench for hysteresis_noise_gate: one predictor of envelope, gate and gain
// checks every output word; depends on hng_pkg and the rtl of the gate
`timescale 1ns / 1ps

module testbench;
  import hng_pkg::*;

  // cycles in which no word moves on either channel before the run is declared hung
  localparam int HANG_LIMIT = 2000;
  // printed mismatch lines are capped, counting goes on
  localparam int REPORT_CAP = 40;

  // expected output word: gated sample and gate flag
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          open;
  } gated_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // input channel, driven from the start of the run
  logic                          in_valid    = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] sample_in   = '0;
  logic                          block_start = 1'b0;

  // output channel
  logic                          out_valid;
  logic                          out_stall   = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          gate_is_open;

  // register write port
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // expected words in order of acceptance
  gated_word_t pending_gated[$];

  // mirror of the register file
  logic [THR_W-1:0]  thr_reg;
  logic [COEF_W-1:0] attack_reg;
  logic [COEF_W-1:0] release_reg;
  logic [COEF_W-1:0] smooth_reg;

  // mirror of the gate state
  logic [ENV_W-1:0]  env_lvl;
  logic              gate_mirror;
  logic [GAIN_W-1:0] gain_lvl;

  // idle limits per side, changed per phase so stretches without gaps occur
  int in_gap_max    = 19;
  int out_stall_max = 19;

  // bookkeeping
  int mismatch_cnt  = 0;
  int words_sent    = 0;
  int words_checked = 0;
  int open_words    = 0;
  int settings_cnt  = 0;
  int quiet_cycles  = 0;

  always #10 clk = ~clk;

  hysteresis_noise_gate i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_in    (sample_in),
    .block_start  (block_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_out   (sample_out),
    .gate_is_open (gate_is_open),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // one-pole move of y toward tgt by c / 2^F of the distance, step truncated
  // so the value never passes the target
  function automatic logic [63:0] glide(input logic [63:0] y, input logic [63:0] tgt,
                                        input logic [COEF_W-1:0] c);
    logic [95:0] stride;
    if (tgt > y) begin
      stride = 96'(tgt - y) * 96'(c);
      return y + 64'(stride >> COEF_FRAC_BITS);
    end
    stride = 96'(y - tgt) * 96'(c);
    return y - 64'(stride >> COEF_FRAC_BITS);
  endfunction

  // advance the mirrored state by one accepted sample and queue the word
  // the gate should produce for it
  task automatic predict_gated_word(input logic [SAMPLE_BITS-1:0] raw, input logic clr);
    logic                   neg;
    logic [SAMPLE_BITS-1:0] mag;
    logic [63:0]            rect;
    logic [63:0]            thr_fix;
    logic [63:0]            prod;
    logic [63:0]            rounded;
    gated_word_t            w;
    neg = raw[SAMPLE_BITS-1];
    // most negative sample keeps its magnitude as an unsigned value
    mag = neg ? -raw : raw;
    if (clr) begin
      env_lvl     = '0;
      gate_mirror = 1'b0;
    end
    // envelope: attack when the rectified sample is above it, release otherwise
    rect    = 64'(mag) << COEF_FRAC_BITS;
    env_lvl = ENV_W'(glide(64'(env_lvl), rect,
                           (rect > 64'(env_lvl)) ? attack_reg : release_reg));
    // hysteresis: open at +3 dB above the close level, close below it
    thr_fix = 64'(thr_reg) << COEF_FRAC_BITS;
    if (!gate_mirror && 64'(env_lvl) * 64'(OPEN_DEN) >= thr_fix * 64'(OPEN_NUM))
      gate_mirror = 1'b1;
    else if (gate_mirror && 64'(env_lvl) < thr_fix)
      gate_mirror = 1'b0;
    // smoothed gain toward 0 or 1.0
    gain_lvl = GAIN_W'(glide(64'(gain_lvl), gate_mirror ? 64'(GAIN_ONE) : 64'd0, smooth_reg));
    // magnitude times gain, rounded half away from zero, sign put back
    prod    = 64'(mag) * 64'(gain_lvl);
    rounded = (prod + (64'd1 << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;
    w.sample = neg ? -rounded[SAMPLE_BITS-1:0] : rounded[SAMPLE_BITS-1:0];
    w.open   = gate_mirror;
    pending_gated.push_back(w);
  endtask

  // ---------------------------------------------------------------------------
  // mismatch reporting
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_CAP)
      $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stall per word and the check of every accepted word
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : out_side
    int          stall_left;
    gated_word_t exp_w;
    if (rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        words_checked++;
        if (gate_is_open === 1'b1)
          open_words++;
        if (pending_gated.size() == 0) begin
          flag_mismatch($sformatf("word with nothing expected: sample %0d open %b",
                                  sample_out, gate_is_open));
        end else begin
          exp_w = pending_gated.pop_front();
          if (sample_out !== exp_w.sample)
            flag_mismatch($sformatf("word %0d sample_out got %0d want %0d",
                                    words_checked, sample_out, exp_w.sample));
          if (gate_is_open !== exp_w.open)
            flag_mismatch($sformatf("word %0d gate_is_open got %b want %b",
                                    words_checked, gate_is_open, exp_w.open));
        end
        // stall drawn fresh after each accepted word
        stall_left = $urandom_range(0, out_stall_max);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // hang watchdog: counts cycles in which neither channel moves a word
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("timeout: no word moved for %0d cycles, %0d words still expected",
                 HANG_LIMIT, pending_gated.size());
        $display("hysteresis_noise_gate verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // offer one sample after a random gap, return at the edge it is taken
  task automatic send_word(input logic [SAMPLE_BITS-1:0] s, input logic clr);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    sample_in   <= s;
    block_start <= clr;
    do @(posedge clk); while (in_stall);
    predict_gated_word(s, clr);
    words_sent++;
  endtask

  // stop offering and wait until every expected word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_gated.size() != 0) @(posedge clk);
  endtask

  // one register write, mirrored after the edge that takes it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_CLOSE_THRESHOLD:  thr_reg     = data[THR_W-1:0];
      REG_ATTACK_COEF:      attack_reg  = data[COEF_W-1:0];
      REG_RELEASE_COEF:     release_reg = data[COEF_W-1:0];
      REG_GAIN_SMOOTH_COEF: smooth_reg  = data[COEF_W-1:0];
      default: ;
    endcase
  endtask

  // new setting while idle; one extra write to an unused index must be ignored
  task automatic configure(input logic [CFG_W-1:0] thr_data, input logic [CFG_W-1:0] att,
                           input logic [CFG_W-1:0] rel, input logic [CFG_W-1:0] smooth);
    drain_results();
    write_reg(REG_CLOSE_THRESHOLD, thr_data);
    write_reg(REG_ATTACK_COEF, att);
    write_reg(REG_RELEASE_COEF, rel);
    write_reg(REG_GAIN_SMOOTH_COEF, smooth);
    write_reg(CFG_IDX_W'($urandom_range(REG_GAIN_SMOOTH_COEF + 1, (1 << CFG_IDX_W) - 1)),
              CFG_W'($urandom));
    cfg_we <= 1'b0;
    settings_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values: gain starts at 1.0, gate closed, default coefficients
  task automatic test_reset_state();
    in_gap_max    = 19;
    out_stall_max = 19;
    send_word(16'sh8000, 1'b1);
    send_word(16'sh7FFF, 1'b0);
    send_word(16'sh0000, 1'b0);
    send_word(16'shFFFF, 1'b0);
    send_word(16'sh0001, 1'b0);
  endtask

  // zero threshold opens at once and never closes, zero coefficients hold;
  // a threshold past any envelope keeps the gate shut; junk above 16 bits
  task automatic test_threshold_extremes();
    in_gap_max    = 0;
    out_stall_max = 19;
    configure(24'hAB0000, 24'hFFFFFF, 24'h000000, 24'h000000);
    send_word(16'sh8000, 1'b1);
    send_word(16'sh0000, 1'b0);
    send_word(16'sh7FFF, 1'b0);
    send_word(16'sh0000, 1'b0);
    in_gap_max    = 19;
    out_stall_max = 0;
    configure(24'h12FFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_word(16'sh7FFF, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh7FFF, 1'b0);
    send_word(16'shFFFF, 1'b0);
  endtask

  // fast follower around a close level of 1000: levels between 1000 and 1414
  // keep whatever state the gate is in, block start forces it shut
  task automatic test_hysteresis();
    in_gap_max    = 5;
    out_stall_max = 5;
    configure(24'd1000, 24'hFFFFFF, 24'hFFFFFF, 24'h400000);
    send_word(16'sd1200, 1'b1);
    send_word(-16'sd1500, 1'b0);
    send_word(16'sd1100, 1'b0);
    send_word(-16'sd900, 1'b0);
    send_word(16'sd1200, 1'b0);
    send_word(16'sd1500, 1'b0);
    send_word(16'sd0, 1'b1);
  endtask

  function automatic logic [CFG_W-1:0] pick_coef(input int floor_val);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 24'hFFFFFF;
      default: return CFG_W'($urandom_range(floor_val, 24'hFFFFFF));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_threshold();
    logic [THR_W-1:0] thr;
    case ($urandom_range(0, 9))
      0:       thr = '0;
      1:       thr = 16'd32768;
      2:       thr = 16'hFFFF;
      default: thr = THR_W'($urandom_range(0, 8000));
    endcase
    // upper bits of the write word carry junk that must be dropped
    return {8'($urandom), thr};
  endfunction

  // phases of random settings; each phase mixes loud bursts, quiet spells,
  // full-range noise and block starts so the gate opens and closes often
  task automatic test_random_program(input int n_words);
    int                     target;
    int                     phase;
    int                     phase_len;
    int                     sent_here;
    int                     kind;
    int                     seg_len;
    int                     level;
    int                     v;
    logic [SAMPLE_BITS-1:0] s;
    logic                   clr;
    target = words_sent + n_words;
    phase  = 0;
    while (words_sent < target) begin
      configure(pick_threshold(), pick_coef(1 << 20), pick_coef(1 << 18), pick_coef(1 << 18));
      // every fourth phase runs with no gaps on either side
      if (phase % 4 == 1) begin
        in_gap_max    = 0;
        out_stall_max = 0;
      end else begin
        in_gap_max    = ($urandom_range(0, 2) == 0) ? 0 : 19;
        out_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
      end
      phase_len = $urandom_range(40, 120);
      sent_here = 0;
      while (sent_here < phase_len && words_sent < target) begin
        kind    = $urandom_range(0, 9);
        seg_len = (kind == 9) ? 1 : $urandom_range(4, 40);
        level   = $urandom_range(256, 32767);
        repeat (seg_len) begin
          clr = ($urandom_range(0, 49) == 0);
          case (kind)
            0, 1, 2, 3, 4: v = level - $urandom_range(0, level / 8);
            5, 6, 7:       v = $urandom_range(0, 48);
            default:       v = $urandom;
          endcase
          s = SAMPLE_BITS'(v);
          if (kind < 8 && $urandom_range(0, 1) == 1)
            s = -s;
          if (kind == 9)
            clr = 1'b1;
          send_word(s, clr);
          sent_here++;
        end
      end
      phase++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------------

  initial begin
    // mirror starts at the reset values of the block
    thr_reg     = THR_W'(THR_RESET);
    attack_reg  = COEF_W'(ATTACK_RESET);
    release_reg = COEF_W'(RELEASE_RESET);
    smooth_reg  = COEF_W'(SMOOTH_RESET);
    env_lvl     = '0;
    gate_mirror = 1'b0;
    gain_lvl    = GAIN_ONE;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_threshold_extremes();
    test_hysteresis();
    test_random_program(830);

    // all words back, then a few cycles to catch any stray extra word
    drain_results();
    repeat (16) @(posedge clk);

    $display("covered %0d samples under %0d register settings, %0d words checked",
             words_sent, settings_cnt, words_checked);
    $display("gate open on %0d words, closed on %0d", open_words,
             words_checked - open_words);
    if (mismatch_cnt == 0 && pending_gated.size() == 0) begin
      $display("hysteresis_noise_gate verification clean");
    end else begin
      $display("%0d mismatches, %0d words never came", mismatch_cnt, pending_gated.size());
      $display("hysteresis_noise_gate verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/hng_pkg.sv
hdl/hysteresis_noise_gate.sv
tb/testbench.sv
